// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int NUM_LEVELS = 5;
    localparam int VALUE_W    = 32;
    localparam int LVL_W      = 3;
    localparam int OCC_W      = 5;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ADDR_W     = LVL_W + PTR_W;
    localparam int NUM_WORDS  = NUM_LEVELS << PTR_W;

    localparam logic       KIND_ENQ  = 1'b0;
    localparam logic       KIND_DEQ  = 1'b1;
    localparam logic [LVL_W-1:0] LEVEL_MIN = LVL_W'(1);
    localparam logic [LVL_W-1:0] LEVEL_MAX = LVL_W'(NUM_LEVELS);

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADLVL = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // update of one level's ring pointers
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [LVL_W-1:0] idx;
        logic [PTR_W-1:0] ptr;
    } t_lvl_cmd;

    // most urgent non-empty level and its head slot
    typedef struct packed {
        logic             any;
        logic [LVL_W-1:0] idx;
        logic [PTR_W-1:0] head;
    } t_lvl_sel;

endpackage

// File: rtl/core/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int DATA_W    = 32,
    parameter int ADDR_W    = 7,
    parameter int NUM_WORDS = 80
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [NUM_WORDS];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/spq_lvl.sv
// ----------------------------------------------------------------------------
// spq_lvl
// Per-level ring pointers and counts, with most-urgent-level selection.
// ----------------------------------------------------------------------------
module spq_lvl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  spq_pkg::t_lvl_cmd        i_cmd,
    input  logic [spq_pkg::LVL_W-1:0] i_enq_idx,
    output spq_pkg::t_lvl_sel        o_sel,
    output logic [spq_pkg::PTR_W-1:0] o_tail
);

    logic [spq_pkg::PTR_W-1:0] r_head [spq_pkg::NUM_LEVELS];
    logic [spq_pkg::PTR_W-1:0] r_tail [spq_pkg::NUM_LEVELS];
    logic [spq_pkg::CNT_W-1:0] r_cnt  [spq_pkg::NUM_LEVELS];
    logic [spq_pkg::NUM_LEVELS-1:0] nonempty;
    logic [spq_pkg::LVL_W-1:0]      sel_idx;

    always_comb begin
        for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
            nonempty[i] = (r_cnt[i] != '0);
        end
    end

    // lowest non-empty index is the most urgent level
    always_comb begin
        sel_idx = '0;
        for (int i = spq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                sel_idx = spq_pkg::LVL_W'(i);
            end
        end
    end

    always_comb begin
        o_sel.any  = |nonempty;
        o_sel.idx  = sel_idx;
        o_sel.head = (sel_idx < spq_pkg::LVL_W'(spq_pkg::NUM_LEVELS)) ?
                     r_head[sel_idx] : '0;
        o_tail     = (i_enq_idx < spq_pkg::LVL_W'(spq_pkg::NUM_LEVELS)) ?
                     r_tail[i_enq_idx] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
                if (i_cmd.idx == spq_pkg::LVL_W'(i)) begin
                    if (i_cmd.push) begin
                        r_tail[i] <= i_cmd.ptr;
                        r_cnt[i]  <= r_cnt[i] + 1'b1;
                    end else if (i_cmd.pop) begin
                        r_head[i] <= i_cmd.ptr;
                        r_cnt[i]  <= r_cnt[i] - 1'b1;
                    end
                end
            end
        end
    end

endmodule

// File: rtl/core/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Five-level stable priority queue; one ring per level in a shared RAM,
// total occupancy bounded by DEPTH.
// ----------------------------------------------------------------------------
// path: the input beat is held in the item register during the RAM read of
//   the head entry, then the result goes to the output register, later while a
//   stalled result beat still holds that register; a new item is taken only
//   after the last one's pointer update, when the core is back in S_IDLE
// reset: synchronous active low; clears counts and pointers, RAM contents
//   are not cleared and are never used before being written
// ----------------------------------------------------------------------------
module stable_priority_queue_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_kind,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_in_value,
    input  logic [spq_pkg::LVL_W-1:0]        i_in_level,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_status,
    output logic signed [spq_pkg::VALUE_W-1:0] o_out_value,
    output logic [spq_pkg::LVL_W-1:0]        o_out_level,
    output logic [spq_pkg::OCC_W-1:0]        o_occupancy
);

    spq_pkg::t_state r_state, n_state;

    logic                          accept;
    logic                          fire;
    logic [spq_pkg::LVL_W-1:0]     enq_idx;
    spq_pkg::t_lvl_sel             sel;
    logic [spq_pkg::PTR_W-1:0]     tail;
    spq_pkg::t_lvl_cmd             cmd;
    logic [spq_pkg::VALUE_W-1:0]   rd_data;

    logic                          r_kind;
    logic [spq_pkg::VALUE_W-1:0]   r_value;
    logic                          r_bad;
    logic                          r_any;
    logic [spq_pkg::LVL_W-1:0]     r_idx;
    logic [spq_pkg::PTR_W-1:0]     r_ptr;
    logic [spq_pkg::CNT_W-1:0]     r_count, n_count;

    logic                          r_out_valid;
    spq_pkg::t_status              r_out_status, n_status;
    logic [spq_pkg::VALUE_W-1:0]   r_out_value, n_value;
    logic [spq_pkg::LVL_W-1:0]     r_out_level, n_level;
    logic [spq_pkg::CNT_W-1:0]     r_out_count;

    logic                          do_push;
    logic                          do_pop;
    logic [spq_pkg::PTR_W-1:0]     ptr_next;

    assign enq_idx = i_in_level - 1'b1;

    spq_lvl u_lvl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_enq_idx (enq_idx),
        .o_sel     (sel),
        .o_tail    (tail)
    );

    spq_ram #(
        .DATA_W    (spq_pkg::VALUE_W),
        .ADDR_W    (spq_pkg::ADDR_W),
        .NUM_WORDS (spq_pkg::NUM_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (do_push),
        .i_wr_addr ({r_idx, r_ptr}),
        .i_wr_data (r_value),
        .i_rd_en   (accept),
        .i_rd_addr ({sel.idx, sel.head}),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = spq_pkg::S_IDLE;
                end
            end
            default: n_state = spq_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall = 1'b1;
        fire    = 1'b0;
        case (r_state)
            spq_pkg::S_IDLE: o_stall = 1'b0;
            spq_pkg::S_EXEC: fire    = !r_out_valid || !i_stall;
            default: begin
                o_stall = 1'b1;
                fire    = 1'b0;
            end
        endcase
    end

    assign accept = i_valid && !o_stall;

    assign ptr_next = (r_ptr == spq_pkg::PTR_W'(spq_pkg::DEPTH - 1)) ? '0 : r_ptr + 1'b1;

    // result of the held item
    always_comb begin
        do_push  = 1'b0;
        do_pop   = 1'b0;
        n_status = spq_pkg::ST_OK;
        n_value  = '0;
        n_level  = '0;
        n_count  = r_count;
        if (r_kind == spq_pkg::KIND_ENQ) begin
            if (r_bad) begin
                n_status = spq_pkg::ST_BADLVL;
            end else if (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                do_push = fire;
                n_count = r_count + 1'b1;
            end
        end else begin
            if (!r_any) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                do_pop  = fire;
                n_value = rd_data;
                n_level = r_idx + 1'b1;
                n_count = r_count - 1'b1;
            end
        end
    end

    always_comb begin
        cmd.push = do_push;
        cmd.pop  = do_pop;
        cmd.idx  = r_idx;
        cmd.ptr  = ptr_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item held across the ram read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_value <= i_in_value;
            r_bad   <= (i_in_level < spq_pkg::LEVEL_MIN) ||
                       (i_in_level > spq_pkg::LEVEL_MAX);
            r_any   <= sel.any;
            r_idx   <= (i_kind == spq_pkg::KIND_ENQ) ? enq_idx : sel.idx;
            r_ptr   <= (i_kind == spq_pkg::KIND_ENQ) ? tail : sel.head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_status <= n_status;
            r_out_value  <= n_value;
            r_out_level  <= n_level;
            r_out_count  <= n_count;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_value = r_out_value;
    assign o_out_level = r_out_level;
    assign o_occupancy = spq_pkg::OCC_W'(r_out_count);

endmodule
